// ===== rtl/ecef_to_enu_geometry_row_assert.svh =====
// Assertion macros used by the checker file of the geometry row block.
`ifndef ECEF_TO_ENU_GEOMETRY_ROW_ASSERT_SVH
`define ECEF_TO_ENU_GEOMETRY_ROW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define E2E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define E2E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ecefenu_pkg.sv =====
// Types, constants and helper functions of the ECEF to ENU geometry row block.
package ecefenu_pkg;

   localparam int FRAC_BITS = 30;
   localparam int PROD_W    = 64;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;

   // register indexes on the csr port
   localparam logic [2:0] REG_SIN_LAT       = 3'd0;
   localparam logic [2:0] REG_COS_LAT       = 3'd1;
   localparam logic [2:0] REG_SIN_LON       = 3'd2;
   localparam logic [2:0] REG_COS_LON       = 3'd3;
   localparam logic [2:0] REG_CLOCK_COLUMNS = 3'd4;
   localparam logic [2:0] REG_FIRST_BOUND   = 3'd5;
   localparam logic [2:0] REG_SECOND_BOUND  = 3'd6;
   localparam logic [2:0] REG_THIRD_BOUND   = 3'd7;

   localparam logic signed [31:0] SIN_RST          = 32'sh0000_0000;
   localparam logic signed [31:0] COS_RST          = 32'sh4000_0000;
   localparam logic [2:0]         CLOCK_COLUMNS_RST = 3'd2;
   localparam logic [7:0]         FIRST_BOUND_RST  = 8'd32;
   localparam logic [7:0]         SECOND_BOUND_RST = 8'd68;
   localparam logic [7:0]         THIRD_BOUND_RST  = 8'd92;

   localparam logic signed [PROD_W-1:0] HALF_PROD = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0]  HALF_SUM  = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0]  ONE_SUM   = 66'sd1 <<< FRAC_BITS;
   localparam logic signed [SUM_W-1:0]  MAX32_SUM = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0]  MIN32_SUM = -66'sd2147483648;
   localparam logic signed [SUM_W-1:0]  TOP_SUM   =
      (ONE_SUM < MAX32_SUM) ? ONE_SUM : MAX32_SUM;
   localparam logic signed [SUM_W-1:0]  BOT_SUM   =
      (-ONE_SUM > MIN32_SUM) ? -ONE_SUM : MIN32_SUM;
   localparam logic signed [31:0] OUT_TOP = TOP_SUM[31:0];
   localparam logic signed [31:0] OUT_BOT = BOT_SUM[31:0];

   typedef struct packed {
      logic signed [31:0] los_x;
      logic signed [31:0] los_y;
      logic signed [31:0] los_z;
      logic [7:0]         sat_number;
      logic               last_row;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] east;
      logic signed [31:0] north;
      logic signed [31:0] up;
      logic [3:0]         clock_bits;
      logic [2:0]         clock_count;
      logic               last_out;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] sin_lat;
      logic signed [31:0] cos_lat;
      logic signed [31:0] sin_lon;
      logic signed [31:0] cos_lon;
      logic [2:0]         clock_columns;
      logic [7:0]         first_bound;
      logic [7:0]         second_bound;
      logic [7:0]         third_bound;
   } cfg_type;

   // rotation coefficients that mix latitude and longitude
   typedef struct packed {
      logic signed [31:0] cl_sl;
      logic signed [31:0] sl_sl;
      logic signed [31:0] cl_cl;
      logic signed [31:0] sl_cl;
   } coef_type;

   // clock-column part of a word, carried alongside the arithmetic
   typedef struct packed {
      logic [3:0] clock_bits;
      logic [2:0] clock_count;
      logic       last_out;
   } side_type;

   localparam logic signed [PROD_W-1:0] CL_CL_PROD_RST = 64'(COS_RST) * 64'(COS_RST);

   // round half up to FRAC_BITS, then saturate to 32 bits
   function automatic logic signed [31:0] coef_round(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = (p + HALF_PROD) >>> FRAC_BITS;
      if (q > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (q < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return q[31:0];
      end
   endfunction

   function automatic side_type clock_tag(input logic [7:0] sat, input logic last,
                                          input cfg_type cfg);
      side_type   s;
      logic [1:0] cls;
      logic [2:0] lim;
      logic [1:0] col;
      if (sat <= cfg.first_bound) begin
         cls = 2'd0;
      end else if (sat <= cfg.second_bound) begin
         cls = 2'd1;
      end else if (sat <= cfg.third_bound) begin
         cls = 2'd2;
      end else begin
         cls = 2'd3;
      end
      lim = cfg.clock_columns - 3'd1;
      col = (cls < lim[1:0]) ? cls : lim[1:0];
      s.last_out = last;
      if (cfg.clock_columns >= 3'd2 && cfg.clock_columns <= 3'd4) begin
         s.clock_count = cfg.clock_columns;
         s.clock_bits  = 4'b0001 | ((cls != 2'd0) ? (4'b0001 << col) : 4'b0000);
      end else begin
         s.clock_count = 3'd0;
         s.clock_bits  = 4'b0000;
      end
      return s;
   endfunction

endpackage

// ===== rtl/ecefenu_csr.sv =====
// Configuration registers and the registered latitude/longitude cross coefficients.
module ecefenu_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   output ecefenu_pkg::cfg_type   cfg,
   output ecefenu_pkg::coef_type  coef
);
   import ecefenu_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic signed [PROD_W-1:0] cl_sl_prod_ff, sl_sl_prod_ff, cl_cl_prod_ff, sl_cl_prod_ff;
   coef_type coef_ff, coef_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SIN_LAT:       cfg_in.sin_lat       = csr_data;
            REG_COS_LAT:       cfg_in.cos_lat       = csr_data;
            REG_SIN_LON:       cfg_in.sin_lon       = csr_data;
            REG_COS_LON:       cfg_in.cos_lon       = csr_data;
            REG_CLOCK_COLUMNS: cfg_in.clock_columns = csr_data[2:0];
            REG_FIRST_BOUND:   cfg_in.first_bound   = csr_data[7:0];
            REG_SECOND_BOUND:  cfg_in.second_bound  = csr_data[7:0];
            REG_THIRD_BOUND:   cfg_in.third_bound   = csr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      coef_in.cl_sl = coef_round(cl_sl_prod_ff);
      coef_in.sl_sl = coef_round(sl_sl_prod_ff);
      coef_in.cl_cl = coef_round(cl_cl_prod_ff);
      coef_in.sl_cl = coef_round(sl_cl_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sin_lat       <= SIN_RST;
         cfg_ff.cos_lat       <= COS_RST;
         cfg_ff.sin_lon       <= SIN_RST;
         cfg_ff.cos_lon       <= COS_RST;
         cfg_ff.clock_columns <= CLOCK_COLUMNS_RST;
         cfg_ff.first_bound   <= FIRST_BOUND_RST;
         cfg_ff.second_bound  <= SECOND_BOUND_RST;
         cfg_ff.third_bound   <= THIRD_BOUND_RST;
         cl_sl_prod_ff        <= '0;
         sl_sl_prod_ff        <= '0;
         cl_cl_prod_ff        <= CL_CL_PROD_RST;
         sl_cl_prod_ff        <= '0;
         coef_ff.cl_sl        <= '0;
         coef_ff.sl_sl        <= '0;
         coef_ff.cl_cl        <= coef_round(CL_CL_PROD_RST);
         coef_ff.sl_cl        <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         cl_sl_prod_ff <= 64'(cfg_ff.cos_lon) * 64'(cfg_ff.sin_lat);
         sl_sl_prod_ff <= 64'(cfg_ff.sin_lon) * 64'(cfg_ff.sin_lat);
         cl_cl_prod_ff <= 64'(cfg_ff.cos_lon) * 64'(cfg_ff.cos_lat);
         sl_cl_prod_ff <= 64'(cfg_ff.sin_lon) * 64'(cfg_ff.cos_lat);
         coef_ff       <= coef_in;
      end
   end

   assign cfg  = cfg_ff;
   assign coef = coef_ff;

endmodule

// ===== rtl/ecefenu_rot.sv =====
// Six-stage rotation pipeline: capture, direct products, coefficient products, pair sums,
// rounding, saturation into the output register.
module ecefenu_rot (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ecefenu_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ecefenu_pkg::rsp_word_type rsp_word,
   input  ecefenu_pkg::cfg_type      cfg,
   input  ecefenu_pkg::coef_type     coef
);
   import ecefenu_pkg::*;

   logic [6:1] vld_ff;
   logic [6:1] adv;

   // stage 1: captured word
   logic signed [31:0] x1_ff, y1_ff, z1_ff;
   side_type           side1_ff;
   // stage 2: products against the plain angle terms
   logic signed [31:0]       x2_ff, y2_ff;
   logic signed [PROD_W-1:0] e0_2_ff, e1_2_ff, nz2_ff, uz2_ff;
   side_type                 side2_ff;
   // stage 3: products against the cross coefficients
   logic signed [PROD_W-1:0] e0_3_ff, e1_3_ff, nz3_ff, uz3_ff;
   logic signed [PROD_W-1:0] nx3_ff, ny3_ff, ux3_ff, uy3_ff;
   side_type                 side3_ff;
   // stage 4: two of three terms summed
   logic signed [PAIR_W-1:0] e_ab4_ff, n_ab4_ff, u_ab4_ff;
   logic signed [PROD_W-1:0] n_c4_ff, u_c4_ff;
   side_type                 side4_ff;
   // stage 5: rounded sums
   logic signed [SUM_W-1:0]  e5_ff, n5_ff, u5_ff;
   side_type                 side5_ff;
   // stage 6: output register
   rsp_word_type             rsp_ff;

   logic signed [SUM_W-1:0]  e_sum, n_sum, u_sum;

   // a stage takes a new word when empty or when its word moves on
   always_comb begin
      adv[6] = !vld_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) vld_ff[1] <= req_valid;
         for (int k = 2; k <= 6; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_comb begin
      e_sum = ((SUM_W'(e_ab4_ff) + HALF_SUM) >>> FRAC_BITS);
      n_sum = ((SUM_W'(n_ab4_ff) + SUM_W'(n_c4_ff) + HALF_SUM) >>> FRAC_BITS);
      u_sum = ((SUM_W'(u_ab4_ff) + SUM_W'(u_c4_ff) + HALF_SUM) >>> FRAC_BITS);
   end

   function automatic logic signed [31:0] clamp_out(input logic signed [SUM_W-1:0] v);
      if (v > TOP_SUM) begin
         return OUT_TOP;
      end else if (v < BOT_SUM) begin
         return OUT_BOT;
      end else begin
         return v[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (adv[1] && req_valid) begin
         x1_ff    <= req_word.los_x;
         y1_ff    <= req_word.los_y;
         z1_ff    <= req_word.los_z;
         side1_ff <= clock_tag(req_word.sat_number, req_word.last_row, cfg);
      end
      if (adv[2] && vld_ff[1]) begin
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         e0_2_ff  <= -(64'(cfg.sin_lon) * 64'(x1_ff));
         e1_2_ff  <= 64'(cfg.cos_lon) * 64'(y1_ff);
         nz2_ff   <= 64'(cfg.cos_lat) * 64'(z1_ff);
         uz2_ff   <= 64'(cfg.sin_lat) * 64'(z1_ff);
         side2_ff <= side1_ff;
      end
      if (adv[3] && vld_ff[2]) begin
         e0_3_ff  <= e0_2_ff;
         e1_3_ff  <= e1_2_ff;
         nz3_ff   <= nz2_ff;
         uz3_ff   <= uz2_ff;
         nx3_ff   <= -(64'(coef.cl_sl) * 64'(x2_ff));
         ny3_ff   <= -(64'(coef.sl_sl) * 64'(y2_ff));
         ux3_ff   <= 64'(coef.cl_cl) * 64'(x2_ff);
         uy3_ff   <= 64'(coef.sl_cl) * 64'(y2_ff);
         side3_ff <= side2_ff;
      end
      if (adv[4] && vld_ff[3]) begin
         e_ab4_ff <= PAIR_W'(e0_3_ff) + PAIR_W'(e1_3_ff);
         n_ab4_ff <= PAIR_W'(nx3_ff) + PAIR_W'(ny3_ff);
         u_ab4_ff <= PAIR_W'(ux3_ff) + PAIR_W'(uy3_ff);
         n_c4_ff  <= nz3_ff;
         u_c4_ff  <= uz3_ff;
         side4_ff <= side3_ff;
      end
      if (adv[5] && vld_ff[4]) begin
         e5_ff    <= e_sum;
         n5_ff    <= n_sum;
         u5_ff    <= u_sum;
         side5_ff <= side4_ff;
      end
      if (adv[6] && vld_ff[5]) begin
         rsp_ff.east        <= clamp_out(e5_ff);
         rsp_ff.north       <= clamp_out(n5_ff);
         rsp_ff.up          <= clamp_out(u5_ff);
         rsp_ff.clock_bits  <= side5_ff.clock_bits;
         rsp_ff.clock_count <= side5_ff.clock_count;
         rsp_ff.last_out    <= side5_ff.last_out;
      end
   end

   assign rsp_valid = vld_ff[6];
   assign rsp_word  = rsp_ff;

endmodule

// ===== rtl/ecef_to_enu_geometry_row.sv =====
// Top level of the ECEF to ENU geometry row block.
// Rotates one Earth-fixed line-of-sight row per word into east, north and up (Q2.30,
// saturated to +/-1.0) and attaches the clock-bias columns picked by the satellite number.
// Takes one word per cycle while req_stall is low; each word passes through the six register
// stages (capture, two multiplier stages, two adder stages, clamp into the output register)
// on its way to rsp.
// Empty stages close up under rsp_stall, so req keeps taking words until the pipe is full.
// The cross coefficients of latitude and longitude are registered products: a csr write
// reaches them through the config, product and coefficient registers in that order.
module ecef_to_enu_geometry_row (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ecefenu_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ecefenu_pkg::rsp_word_type rsp_word,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import ecefenu_pkg::*;

   cfg_type  cfg;
   coef_type coef;

   ecefenu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .coef      (coef)
   );

   ecefenu_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .cfg       (cfg),
      .coef      (coef)
   );

endmodule

// ===== rtl/ecefenu_checker.sv =====
// Port-level checker of the ECEF to ENU geometry row block and its bind.
module ecefenu_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input ecefenu_pkg::req_word_type req_word,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input ecefenu_pkg::rsp_word_type rsp_word
);
   import ecefenu_pkg::*;
   `include "ecef_to_enu_geometry_row_assert.svh"

   logic req_held;
   logic rsp_held;
   logic cols_ok;
   logic enu_ok;

   assign req_held = req_valid && req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign cols_ok  = (rsp_word.clock_count == 3'd0 && rsp_word.clock_bits == 4'd0) ||
                     ((rsp_word.clock_count == 3'd2 || rsp_word.clock_count == 3'd3 ||
                       rsp_word.clock_count == 3'd4) && rsp_word.clock_bits[0] &&
                      $countones(rsp_word.clock_bits) <= 2);
   assign enu_ok   = rsp_word.east <= OUT_TOP && rsp_word.east >= OUT_BOT &&
                     rsp_word.north <= OUT_TOP && rsp_word.north >= OUT_BOT &&
                     rsp_word.up <= OUT_TOP && rsp_word.up >= OUT_BOT;

   // hold a stalled request word
   `E2E_ASSERT_NEXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_word), "req not held")
   // hold a stalled result word
   `E2E_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word), "rsp not held")
   // an unstalled output means no back pressure on req
   `E2E_ASSERT_NOW(a_req_free, clock, reset, !rsp_stall, !req_stall, "req stalled while rsp drains")
   `E2E_ASSERT_NOW(a_clock_cols, clock, reset, rsp_valid, cols_ok, "bad clock columns")
   `E2E_ASSERT_NOW(a_saturate, clock, reset, rsp_valid, enu_ok, "result outside +/-1.0")

endmodule

bind ecef_to_enu_geometry_row ecefenu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
